[design/lbrwe_pkg.sv]
// types and constants shared by the led blink and relay word engine
`default_nettype none

package lbrwe_pkg;

    localparam int NUM_LEDS = 9;

    typedef enum logic [1:0] {
        CMD_TICK    = 2'd0,
        CMD_SET     = 2'd1,
        CMD_RESTORE = 2'd2,
        CMD_BLINK   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OFF  = 2'd0,
        ST_ON   = 2'd1,
        ST_FAST = 2'd2,
        ST_SLOW = 2'd3
    } t_led_state;

    typedef enum logic [1:0] {
        CFG_CHANNEL_SELECT = 2'd0,
        CFG_AB_SELECT      = 2'd1,
        CFG_OUTPUT_MODE    = 2'd2,
        CFG_UNUSED         = 2'd3
    } t_cfg_index;

    // led positions
    localparam int IDX_CH1  = 0;
    localparam int IDX_CH2  = 1;
    localparam int IDX_CH3  = 2;
    localparam int IDX_CH4  = 3;
    localparam int IDX_A    = 4;
    localparam int IDX_B    = 5;
    localparam int IDX_LOOP = 6;
    localparam int IDX_GRN  = 7;
    localparam int IDX_RED  = 8;

    localparam logic [5:0] TICK_HALF        = 6'd25;
    localparam logic [5:0] TICK_WRAP        = 6'd50;
    localparam logic [7:0] BUDGET_UNLIMITED = 8'd255;

endpackage

`default_nettype wire

[design/led_blink_relay_word_engine.sv]
// led blink engine and relay/led shift word former, top level
//
// Input channel (i_valid / o_stall) carries one command item: tick, set led
// state, restore previous state, or counted fast blink. An item is taken at
// a rising edge with i_valid high and o_stall low. Only a tick item makes a
// result; the other commands update led state and produce nothing.
// Output channel (o_valid / i_stall) carries the 16-bit shift word. A tick's
// word is registered in the result register, or in the skid register while
// an untaken word waits there. Throughput is one item per cycle while
// o_stall is low: all nine led updates and the word are formed by one pass
// of logic from the state registers into a two-entry output queue (result
// register plus skid register). o_stall rises only when both entries hold
// words, i.e. the receiver stalled a pending word and another tick arrived.
// Configuration writes (i_cfg_valid / o_cfg_ready) are always ready and
// take effect from the next tick; index 3 is ignored.
// Synchronous active-low reset: all leds off, previous states off, blink
// budgets unlimited, tick counter and both phases zero, registers zero,
// output queue empty.
`default_nettype none

module led_blink_relay_word_engine (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_cmd,
    input  wire logic [3:0]  i_led_index,
    input  wire logic [1:0]  i_led_state,
    input  wire logic [6:0]  i_blink_times,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [15:0]      o_shift_word,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [1:0]  i_cfg_data
);
    import lbrwe_pkg::*;

    t_led_state r_cur    [NUM_LEDS];
    t_led_state r_prev   [NUM_LEDS];
    logic [7:0] r_budget [NUM_LEDS];
    t_led_state n_cur    [NUM_LEDS];
    t_led_state n_prev   [NUM_LEDS];
    logic [7:0] n_budget [NUM_LEDS];

    logic [5:0] r_tick, n_tick;
    logic       r_fast, n_fast;
    logic       r_slow, n_slow;

    logic [1:0] r_channel_select;
    logic       r_ab_select;
    logic       r_output_mode;

    logic        r_out_valid, r_skid_valid;
    logic [15:0] r_out_word, r_skid_word;

    logic        accept, push, pop;
    t_cmd        cmd;
    t_led_state  new_state;
    logic        dec;
    logic [NUM_LEDS-1:0] lit;
    logic        grn_lit;
    logic        r13_24, r1_3, r2_4;
    logic [15:0] word;

    assign cmd       = t_cmd'(i_cmd);
    assign new_state = t_led_state'(i_led_state);
    assign accept    = i_valid && !o_stall;
    assign push      = accept && (cmd == CMD_TICK);
    assign pop       = r_out_valid && !i_stall;

    assign o_stall      = r_skid_valid;
    assign o_valid      = r_out_valid;
    assign o_shift_word = r_out_word;
    assign o_cfg_ready  = 1'b1;

    always_comb begin
        for (int i = 0; i < NUM_LEDS; i++) begin
            n_cur[i]    = r_cur[i];
            n_prev[i]   = r_prev[i];
            n_budget[i] = r_budget[i];
        end
        n_tick = r_tick;
        n_fast = r_fast;
        n_slow = r_slow;
        dec    = (r_tick == TICK_HALF) || (r_tick == TICK_WRAP);
        lit    = '0;

        // phases as they stand after this tick
        if (dec) begin
            n_fast = !r_fast;
        end
        if (r_tick >= TICK_WRAP) begin
            n_slow = !r_slow;
        end

        for (int i = 0; i < NUM_LEDS; i++) begin
            unique case (r_cur[i])
                ST_OFF:  lit[i] = 1'b0;
                ST_ON:   lit[i] = 1'b1;
                ST_FAST: lit[i] = n_fast;
                ST_SLOW: lit[i] = n_slow;
                default: lit[i] = 1'b0;
            endcase
        end

        // green: its own blink is inverted, red blinking overrides it
        priority case (1'b1)
            r_cur[IDX_RED] == ST_FAST: grn_lit = !n_fast;
            r_cur[IDX_RED] == ST_SLOW: grn_lit = !n_slow;
            r_cur[IDX_GRN] == ST_FAST: grn_lit = !n_fast;
            r_cur[IDX_GRN] == ST_SLOW: grn_lit = !n_slow;
            default:                   grn_lit = lit[IDX_GRN];
        endcase

        if (accept) begin
            unique case (cmd)
                CMD_TICK: begin
                    n_tick = (r_tick >= TICK_WRAP) ? '0 : r_tick + 6'd1;
                    for (int i = 0; i < NUM_LEDS; i++) begin
                        if (r_cur[i] == ST_FAST && r_budget[i] != BUDGET_UNLIMITED) begin
                            if (r_budget[i] == 8'd0) begin
                                n_cur[i]    = r_prev[i];
                                n_budget[i] = BUDGET_UNLIMITED;
                            end else begin
                                n_budget[i] = r_budget[i] - {7'd0, dec};
                            end
                        end
                    end
                end
                CMD_SET: begin
                    for (int i = 0; i < NUM_LEDS; i++) begin
                        if (i_led_index == 4'(i) && r_cur[i] != new_state) begin
                            n_prev[i] = r_cur[i];
                            n_cur[i]  = new_state;
                        end
                    end
                end
                CMD_RESTORE: begin
                    for (int i = 0; i < NUM_LEDS; i++) begin
                        if (i_led_index == 4'(i)) begin
                            n_cur[i] = r_prev[i];
                        end
                    end
                end
                CMD_BLINK: begin
                    for (int i = 0; i < NUM_LEDS; i++) begin
                        if (i_led_index == 4'(i)) begin
                            if (r_cur[i] != ST_FAST) begin
                                n_prev[i] = r_cur[i];
                            end
                            n_cur[i]    = ST_FAST;
                            n_budget[i] = {i_blink_times, 1'b0};
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign r13_24 = (r_channel_select == 2'd1) || (r_channel_select == 2'd3);
    assign r1_3   = (r_channel_select == 2'd2);
    assign r2_4   = (r_channel_select == 2'd3);

    assign word = {1'b0, r_ab_select, lit[IDX_LOOP], lit[IDX_RED], grn_lit,
                   lit[IDX_B], lit[IDX_A], r2_4, r_output_mode, 1'b0,
                   lit[IDX_CH4], lit[IDX_CH2], lit[IDX_CH1], lit[IDX_CH3],
                   r1_3, r13_24};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_LEDS; i++) begin
                r_cur[i]    <= ST_OFF;
                r_prev[i]   <= ST_OFF;
                r_budget[i] <= BUDGET_UNLIMITED;
            end
            r_tick <= '0;
            r_fast <= 1'b0;
            r_slow <= 1'b0;
        end else begin
            for (int i = 0; i < NUM_LEDS; i++) begin
                r_cur[i]    <= n_cur[i];
                r_prev[i]   <= n_prev[i];
                r_budget[i] <= n_budget[i];
            end
            if (push) begin
                r_tick <= n_tick;
                r_fast <= n_fast;
                r_slow <= n_slow;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channel_select <= '0;
            r_ab_select      <= 1'b0;
            r_output_mode    <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_CHANNEL_SELECT: r_channel_select <= i_cfg_data;
                CFG_AB_SELECT:      r_ab_select      <= i_cfg_data[0];
                CFG_OUTPUT_MODE:    r_output_mode    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // two-entry output queue: result register in front, skid behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (pop) begin
                if (r_skid_valid) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= push;
                end
            end else if (push) begin
                if (!r_out_valid) begin
                    r_out_valid <= 1'b1;
                end else begin
                    r_skid_valid <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            if (r_skid_valid) begin
                r_out_word <= r_skid_word;
            end else if (push) begin
                r_out_word <= word;
            end
        end else if (push) begin
            if (!r_out_valid) begin
                r_out_word <= word;
            end else begin
                r_skid_word <= word;
            end
        end
    end

endmodule

`default_nettype wire

[design/lbrwe_checker.sv]
// port-level checker for the led blink and relay word engine, with its bind
`default_nettype none

module lbrwe_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_stall,
    input wire logic [1:0]  i_cmd,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [15:0] o_shift_word
);
    import lbrwe_pkg::*;

    // queue is empty right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("output valid or stall after reset");

    // an accepted tick always leaves a word waiting
    a_tick_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_cmd == CMD_TICK) |=> o_valid)
        else $error("accepted tick produced no word");

    // input backpressure only after the receiver held off a pending word
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_stall) |-> $past(o_valid && i_stall))
        else $error("input stalled without output backpressure");

    a_hold_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid && $stable(o_shift_word))
        else $error("stalled word changed or dropped");

endmodule

bind led_blink_relay_word_engine lbrwe_checker u_lbrwe_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_stall      (o_stall),
    .i_cmd        (i_cmd),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_shift_word (o_shift_word)
);

`default_nettype wire

[dv/lbrwe_shift_word_checker.sv]
// shift word checker: watches the led engine channels, predicts each word and compares
module lbrwe_shift_word_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_stall,
    input  wire logic [1:0]  i_cmd,
    input  wire logic [3:0]  i_led_index,
    input  wire logic [1:0]  i_led_state,
    input  wire logic [6:0]  i_blink_times,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_stall,
    input  wire logic [15:0] i_shift_word,
    input  wire logic        i_cfg_valid,
    input  wire logic        i_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [1:0]  i_cfg_data,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_words_checked
);
    timeunit 1ns;
    timeprecision 1ps;
    import lbrwe_pkg::*;

    // channel_select settings
    localparam logic [1:0] CHAN_NONE   = 2'd0;
    localparam logic [1:0] CHAN_13_24  = 2'd1;
    localparam logic [1:0] CHAN_1_3    = 2'd2;
    localparam logic [1:0] CHAN_BOTH   = 2'd3;

    t_led_state  led_cur  [NUM_LEDS];
    t_led_state  led_prev [NUM_LEDS];
    logic [7:0]  budget   [NUM_LEDS];
    logic [5:0]  tick_cnt;
    logic        fast_ph;
    logic        slow_ph;
    logic [1:0]  chan_sel;
    logic        ab_sel;
    logic        ohm_mode;
    logic [15:0] expected_words[$];

    task automatic clear_engine();
        for (int i = 0; i < NUM_LEDS; i++) begin
            led_cur[i]  = ST_OFF;
            led_prev[i] = ST_OFF;
            budget[i]   = BUDGET_UNLIMITED;
        end
        tick_cnt = '0;
        fast_ph  = 1'b0;
        slow_ph  = 1'b0;
        chan_sel = CHAN_NONE;
        ab_sel   = 1'b0;
        ohm_mode = 1'b0;
        expected_words.delete();
    endtask

    // advances the tick state and forms the word this tick shifts out
    function automatic logic [15:0] next_shift_word();
        logic [NUM_LEDS-1:0] lit;
        logic                dec;
        logic [15:0]         w;
        dec = (tick_cnt == TICK_HALF) || (tick_cnt == TICK_WRAP);
        if (dec) fast_ph = ~fast_ph;
        if (tick_cnt >= TICK_WRAP) begin
            tick_cnt = '0;
            slow_ph  = ~slow_ph;
        end else begin
            tick_cnt = tick_cnt + 6'd1;
        end
        lit = '0;
        // index order matters: the last led to touch grn wins
        for (int i = 0; i < NUM_LEDS; i++) begin
            case (led_cur[i])
                ST_OFF: lit[i] = 1'b0;
                ST_ON:  lit[i] = 1'b1;
                ST_FAST: begin
                    lit[i]       = fast_ph;
                    lit[IDX_GRN] = ~fast_ph;
                    if (budget[i] != BUDGET_UNLIMITED) begin
                        if (budget[i] == 8'd0) begin
                            led_cur[i] = led_prev[i];
                            budget[i]  = BUDGET_UNLIMITED;
                        end else begin
                            budget[i] = budget[i] - {7'd0, dec};
                        end
                    end
                end
                default: begin
                    lit[i]       = slow_ph;
                    lit[IDX_GRN] = ~slow_ph;
                end
            endcase
        end
        w     = '0;
        w[0]  = (chan_sel == CHAN_13_24) || (chan_sel == CHAN_BOTH);
        w[1]  = (chan_sel == CHAN_1_3);
        w[2]  = lit[IDX_CH3];
        w[3]  = lit[IDX_CH1];
        w[4]  = lit[IDX_CH2];
        w[5]  = lit[IDX_CH4];
        w[7]  = ohm_mode;
        w[8]  = (chan_sel == CHAN_BOTH);
        w[9]  = lit[IDX_A];
        w[10] = lit[IDX_B];
        w[11] = lit[IDX_GRN];
        w[12] = lit[IDX_RED];
        w[13] = lit[IDX_LOOP];
        w[14] = ab_sel;
        return w;
    endfunction

    task automatic apply_led_cmd(input t_cmd c, input logic [3:0] idx, input logic [1:0] st,
                                 input logic [6:0] n);
        if (idx < NUM_LEDS) begin
            case (c)
                CMD_SET: begin
                    if (led_cur[idx] != t_led_state'(st)) begin
                        led_prev[idx] = led_cur[idx];
                        led_cur[idx]  = t_led_state'(st);
                    end
                end
                CMD_RESTORE: led_cur[idx] = led_prev[idx];
                CMD_BLINK: begin
                    if (led_cur[idx] != ST_FAST) led_prev[idx] = led_cur[idx];
                    led_cur[idx] = ST_FAST;
                    budget[idx]  = {n, 1'b0};
                end
                default: ;
            endcase
        end
    endtask

    initial begin
        o_fail_count    = 0;
        o_pending       = 0;
        o_words_checked = 0;
        clear_engine();
    end

    always @(posedge i_clk) begin
        logic [15:0] want;
        if (!i_rst_n) begin
            clear_engine();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_CHANNEL_SELECT: chan_sel = i_cfg_data;
                    CFG_AB_SELECT:      ab_sel   = i_cfg_data[0];
                    CFG_OUTPUT_MODE:    ohm_mode = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_words.size() == 0) begin
                    $display("%0t: shift_word %04h arrived with none expected", $time,
                             i_shift_word);
                    o_fail_count++;
                end else begin
                    want = expected_words.pop_front();
                    o_words_checked++;
                    if (i_shift_word !== want) begin
                        $display("%0t: shift_word expected %04h actual %04h", $time, want,
                                 i_shift_word);
                        o_fail_count++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (t_cmd'(i_cmd) == CMD_TICK) expected_words.push_back(next_shift_word());
                else apply_led_cmd(t_cmd'(i_cmd), i_led_index, i_led_state, i_blink_times);
            end
        end
        o_pending = expected_words.size();
    end

endmodule

[dv/tb_led_blink_relay_word_engine.sv]
// testbench top for the led blink and relay word engine: stimulus and verdict
module tb_led_blink_relay_word_engine;
    timeunit 1ns;
    timeprecision 1ps;
    import lbrwe_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int HOLD_CYCLES   = 200;
    localparam int PHASE_ITEMS   = 310;
    localparam int NUM_PHASES    = 6;
    localparam int SETTLE_CYCLES = 3;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    t_cmd        cmd;
    logic [3:0]  led_index;
    logic [1:0]  led_state;
    logic [6:0]  blink_times;
    logic        out_valid;
    logic        out_stall;
    logic [15:0] shift_word;
    logic        cfg_valid;
    logic        cfg_ready;
    t_cfg_index  cfg_index;
    logic [1:0]  cfg_data;

    int fail_count;
    int pending;
    int words_checked;
    int cycle_cnt = 0;
    int items_sent = 0;
    int ignored_sent = 0;
    int hold_requests = 0;
    int hold_seen = 0;
    int hold_left = 0;
    bit send_idle_on = 1'b1;
    bit recv_idle_on = 1'b1;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    led_blink_relay_word_engine dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_valid       (in_valid),
        .o_stall       (in_stall),
        .i_cmd         (cmd),
        .i_led_index   (led_index),
        .i_led_state   (led_state),
        .i_blink_times (blink_times),
        .o_valid       (out_valid),
        .i_stall       (out_stall),
        .o_shift_word  (shift_word),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data)
    );

    lbrwe_shift_word_checker checker_i (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_cmd           (cmd),
        .i_led_index     (led_index),
        .i_led_state     (led_state),
        .i_blink_times   (blink_times),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_shift_word    (shift_word),
        .i_cfg_valid     (cfg_valid),
        .i_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_words_checked (words_checked)
    );

    // receiver: random stalls, plus a long hold-off whenever one is requested
    always @(negedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else if (hold_seen != hold_requests) begin
            hold_seen = hold_requests;
            hold_left = HOLD_CYCLES;
            out_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else begin
            out_stall <= recv_idle_on && ($urandom_range(99) < 34);
        end
    end

    always @(posedge clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words still expected", cycle_cnt, pending);
            $display("FAIL led_blink_relay_word_engine");
            $finish;
        end
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_item(input t_cmd c, input logic [3:0] idx, input logic [1:0] st,
                             input logic [6:0] n);
        while (send_idle_on && ($urandom_range(99) < 34)) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        cmd         <= c;
        led_index   <= idx;
        led_state   <= st;
        blink_times <= n;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
        items_sent++;
    endtask

    function automatic logic [6:0] pick_blink_count();
        int r;
        r = $urandom_range(99);
        if (r < 70) return 7'($urandom_range(3));
        if (r < 95) return 7'($urandom_range(20, 4));
        return 7'($urandom_range(127));
    endfunction

    // returns 1 when the item is one the engine acts on
    task automatic send_random_item(output bit counted);
        int r;
        r = $urandom_range(99);
        counted = 1'b1;
        if (r < 68) begin
            // unused fields of a tick still toggle
            send_item(CMD_TICK, 4'($urandom_range(15)), 2'($urandom_range(3)),
                      7'($urandom_range(127)));
        end else if (r < 80) begin
            send_item(CMD_SET, 4'($urandom_range(8)), 2'($urandom_range(3)),
                      7'($urandom_range(127)));
        end else if (r < 87) begin
            send_item(CMD_RESTORE, 4'($urandom_range(8)), 2'($urandom_range(3)),
                      7'($urandom_range(127)));
        end else if (r < 96) begin
            send_item(CMD_BLINK, 4'($urandom_range(8)), 2'($urandom_range(3)),
                      pick_blink_count());
        end else begin
            // led index past the last led: ignored by the engine
            send_item(t_cmd'($urandom_range(3, 1)), 4'($urandom_range(15, 9)),
                      2'($urandom_range(3)), 7'($urandom_range(127)));
            counted = 1'b0;
            ignored_sent++;
        end
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic program_regs(input logic [1:0] chan, input logic ab, input logic mode);
        t_cfg_index  idx_list  [4];
        logic [1:0]  data_list [4];
        idx_list  = '{CFG_CHANNEL_SELECT, CFG_AB_SELECT, CFG_OUTPUT_MODE, CFG_UNUSED};
        // only bit 0 counts for the one-bit registers
        data_list = '{chan, {1'($urandom_range(1)), ab}, {1'($urandom_range(1)), mode},
                      2'($urandom_range(3))};
        for (int i = 0; i < 4; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx_list[i];
            cfg_data  <= data_list[i];
            @(posedge clk);
            while (!cfg_ready) @(posedge clk);
            @(negedge clk);
        end
        cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [1:0] chan;
        logic       ab;
        logic       mode;
        bit         counted;
        int         done;

        rst_n       = 1'b0;
        in_valid    = 1'b0;
        cmd         = CMD_TICK;
        led_index   = '0;
        led_state   = '0;
        blink_times = '0;
        cfg_valid   = 1'b0;
        cfg_index   = CFG_CHANNEL_SELECT;
        cfg_data    = '0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed items under reset register values
        send_item(CMD_TICK,    4'd0,          ST_OFF,  7'd0);
        send_item(CMD_SET,     4'(IDX_CH1),   ST_ON,   7'd0);
        send_item(CMD_SET,     4'(IDX_CH2),   ST_FAST, 7'd0);
        send_item(CMD_SET,     4'(IDX_CH3),   ST_SLOW, 7'd127);
        send_item(CMD_SET,     4'(IDX_CH3),   ST_SLOW, 7'd0);   // same state, previous kept
        send_item(CMD_TICK,    4'd15,         ST_SLOW, 7'd127);
        send_item(CMD_BLINK,   4'(IDX_CH4),   ST_OFF,  7'd0);   // zero budget restores at the next tick
        send_item(CMD_BLINK,   4'(IDX_A),     ST_ON,   7'd127);
        send_item(CMD_BLINK,   4'(IDX_A),     ST_OFF,  7'd1);   // already fast, previous kept
        send_item(CMD_SET,     4'(IDX_GRN),   ST_ON,   7'd0);
        send_item(CMD_SET,     4'(IDX_RED),   ST_FAST, 7'd0);
        send_item(CMD_TICK,    4'd8,          ST_ON,   7'd64);
        send_item(CMD_RESTORE, 4'(IDX_CH1),   ST_OFF,  7'd0);
        send_item(CMD_RESTORE, 4'(IDX_B),     ST_SLOW, 7'd0);
        send_item(CMD_SET,     4'd15,         ST_ON,   7'd0);
        send_item(CMD_BLINK,   4'd9,          ST_OFF,  7'd5);
        send_item(CMD_RESTORE, 4'd12,         ST_OFF,  7'd0);
        send_item(CMD_SET,     4'(IDX_LOOP),  ST_SLOW, 7'd0);
        send_item(CMD_SET,     4'(IDX_GRN),   ST_SLOW, 7'd0);
        send_item(CMD_BLINK,   4'(IDX_B),     ST_ON,   7'd2);
        for (int i = 0; i < 5; i++) send_item(CMD_TICK, 4'd0, ST_OFF, 7'd0);
        wait_idle();

        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: begin chan = 2'd3; ab = 1'b1; mode = 1'b1; end
                1: begin chan = 2'd0; ab = 1'b0; mode = 1'b0; end
                2: begin chan = 2'd2; ab = 1'b1; mode = 1'b0; end
                3: begin chan = 2'd1; ab = 1'b0; mode = 1'b1; end
                default: begin
                    chan = 2'($urandom_range(3));
                    ab   = 1'($urandom_range(1));
                    mode = 1'($urandom_range(1));
                end
            endcase
            program_regs(chan, ab, mode);
            // first phase runs back to back on both sides
            send_idle_on = (p != 0);
            recv_idle_on = (p != 0);
            if (p == 2) hold_requests++;
            done = 0;
            while (done < PHASE_ITEMS) begin
                send_random_item(counted);
                if (counted) done++;
            end
            wait_idle();
        end

        $display("sent %0d items (%0d with an out-of-range led) over %0d register settings,",
                 items_sent, ignored_sent, NUM_PHASES + 1);
        $display("checked %0d shift words, %0d failures", words_checked, fail_count);
        if (fail_count == 0) begin
            $display("PASS led_blink_relay_word_engine");
        end else begin
            $display("FAIL led_blink_relay_word_engine");
        end
        $finish;
    end

endmodule
